// ===== rtl/tgc_pkg.sv =====
// Shared types and constants for the touch gesture classifier.
// No dependencies; every module file imports this package.
package tgc_pkg;

  localparam int CoordBits   = 12;
  localparam int ThreshBits  = 12;
  localparam int TickBits    = 16;
  localparam int TapBits     = 32;
  localparam int CfgIdxBits  = 4;
  localparam int CfgDataBits = 16;

  localparam logic [TickBits-1:0]   LongPressTicksRst = TickBits'(20);
  localparam logic [ThreshBits-1:0] SwipeThresholdRst = ThreshBits'(30);

  localparam logic [CfgIdxBits-1:0] CfgIdxLongPress = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgIdxSwipe     = CfgIdxBits'(1);

  localparam logic KindPress   = 1'b0;
  localparam logic KindRelease = 1'b1;

  typedef enum logic [2:0] {
    EvStart = 3'd0,
    EvLong  = 3'd1,
    EvTap   = 3'd2,
    EvRight = 3'd3,
    EvLeft  = 3'd4,
    EvDown  = 3'd5,
    EvUp    = 3'd6
  } event_code_e;

  typedef struct packed {
    logic                 kind;
    logic [CoordBits-1:0] pos_x;
    logic [CoordBits-1:0] pos_y;
  } sample_t;

  typedef struct packed {
    event_code_e          event_code;
    logic [CoordBits-1:0] event_x;
    logic [CoordBits-1:0] event_y;
    logic [TapBits-1:0]   tap_total;
  } event_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0]  index;
    logic [CfgDataBits-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [TickBits-1:0]   long_press_ticks;
    logic [ThreshBits-1:0] swipe_min;
  } cfg_t;

endpackage

// ===== rtl/tgc_chan_if.sv =====
// Valid/ready channel carrying one payload per beat.
// The payload type is set where the channel is instantiated.
interface tgc_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/tgc_cfg_regs.sv =====
// Configuration registers of the touch gesture classifier.
// Depends on tgc_pkg and tgc_chan_if.
module tgc_cfg_regs
  import tgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tgc_chan_if.sink    cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.payload.index == CfgIdxLongPress) begin
        cfg_d.long_press_ticks = cfg_i.payload.data[TickBits-1:0];
      end else if (cfg_i.payload.index == CfgIdxSwipe) begin
        cfg_d.swipe_min = cfg_i.payload.data[ThreshBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= LongPressTicksRst;
      cfg_q.swipe_min        <= SwipeThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tgc_tracker.sv =====
// Touch state and gesture decision for one registered sample per cycle in which step_i is high.
// Depends on tgc_pkg.
module tgc_tracker
  import tgc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  sample_t sample_i,
  input  cfg_t    cfg_i,
  output logic    res_valid_o,
  output event_t  res_o
);

  logic                 active_q, active_d;
  logic                 long_q, long_d;
  logic [TickBits-1:0]  held_q, held_d;
  logic [CoordBits-1:0] origin_x_q, origin_x_d;
  logic [CoordBits-1:0] origin_y_q, origin_y_d;
  logic [TapBits-1:0]   taps_q, taps_d;

  logic signed [CoordBits:0] dx, dy;
  logic [CoordBits:0]        ax_w, ay_w;
  logic [CoordBits-1:0]      ax, ay;
  logic [TickBits-1:0]       held_inc;
  event_code_e               code;

  assign dx   = $signed({1'b0, sample_i.pos_x}) - $signed({1'b0, origin_x_q});
  assign dy   = $signed({1'b0, sample_i.pos_y}) - $signed({1'b0, origin_y_q});
  assign ax_w = dx[CoordBits] ? (CoordBits+1)'(-dx) : dx;
  assign ay_w = dy[CoordBits] ? (CoordBits+1)'(-dy) : dy;
  assign ax   = ax_w[CoordBits-1:0];
  assign ay   = ay_w[CoordBits-1:0];

  assign held_inc = (held_q == '1) ? held_q : held_q + TickBits'(1);

  always_comb begin
    active_d    = active_q;
    long_d      = long_q;
    held_d      = held_q;
    origin_x_d  = origin_x_q;
    origin_y_d  = origin_y_q;
    taps_d      = taps_q;
    res_valid_o = 1'b0;
    code        = EvStart;
    if (step_i) begin
      if (sample_i.kind == KindPress) begin
        if (!active_q) begin
          active_d    = 1'b1;
          long_d      = 1'b0;
          held_d      = TickBits'(1);
          origin_x_d  = sample_i.pos_x;
          origin_y_d  = sample_i.pos_y;
          res_valid_o = 1'b1;
          code        = EvStart;
        end else begin
          held_d = held_inc;
          if (held_inc >= cfg_i.long_press_ticks && !long_q) begin
            long_d      = 1'b1;
            res_valid_o = 1'b1;
            code        = EvLong;
          end
        end
      end else if (active_q) begin
        res_valid_o = 1'b1;
        if (long_q) begin
          code = EvLong;
        end else if (ax < cfg_i.swipe_min && ay < cfg_i.swipe_min) begin
          code   = EvTap;
          taps_d = taps_q + TapBits'(1);
        end else if (ax >= ay) begin
          code = (!dx[CoordBits] && dx != '0) ? EvRight : EvLeft;
        end else begin
          code = (!dy[CoordBits] && dy != '0) ? EvDown : EvUp;
        end
        active_d   = 1'b0;
        long_d     = 1'b0;
        held_d     = '0;
        origin_x_d = '0;
        origin_y_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      long_q     <= 1'b0;
      held_q     <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
      taps_q     <= '0;
    end else begin
      active_q   <= active_d;
      long_q     <= long_d;
      held_q     <= held_d;
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
      taps_q     <= taps_d;
    end
  end

  assign res_o.event_code = code;
  assign res_o.event_x    = sample_i.pos_x;
  assign res_o.event_y    = sample_i.pos_y;
  assign res_o.tap_total  = taps_d;

  a_long_needs_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_q |-> active_q)
    else $error("long press flag set without an active touch");

  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> held_q == '0)
    else $error("held count not clear while idle");

  a_tap_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taps_q != $past(taps_q)) |->
      (taps_q == $past(taps_q) + TapBits'(1)) &&
      $past(step_i && res_valid_o && res_o.event_code == EvTap))
    else $error("tap total moved without a tap event");

  a_idle_release_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && sample_i.kind == KindRelease && !active_q) |-> !res_valid_o)
    else $error("release while idle produced an event");

endmodule

// ===== rtl/touch_gesture_classifier.sv =====
// Touch gesture classifier: start, long press, tap and four swipe directions.
// An accepted sample beat is held in the sample register; its event beat, if any, is
// held in the event register. Throughput is one sample per cycle unless the event
// output stalls, set by the single decision stage between the two registers.
// Reset clears the touch state, the tap total and the valid flags of both
// pipeline registers, and loads the long-press and swipe registers with defaults.
module touch_gesture_classifier
  import tgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tgc_chan_if.sink    sample_i,
  tgc_chan_if.sink    cfg_i,
  tgc_chan_if.source  event_o
);

  logic    in_valid_q, in_valid_d;
  sample_t in_q;
  logic    out_valid_q, out_valid_d;
  event_t  out_q;
  logic    step;
  logic    res_valid;
  event_t  res;
  cfg_t    cfg;

  tgc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tgc_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .sample_i    (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign step           = in_valid_q && (!out_valid_q || event_o.ready);
  assign sample_i.ready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (sample_i.valid && sample_i.ready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && res_valid) begin
      out_valid_d = 1'b1;
    end else if (event_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      in_q <= sample_i.payload;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign event_o.valid   = out_valid_q;
  assign event_o.payload = out_q;

endmodule
